// File: design/usage_ranked_register_slot_assigner_core_assert.svh
// assertion macros for the usage ranked slot assigner
// expects clk and arst_n in the scope of the module that uses them
`ifndef USAGE_RANKED_REGISTER_SLOT_ASSIGNER_CORE_ASSERT_SVH
`define USAGE_RANKED_REGISTER_SLOT_ASSIGNER_CORE_ASSERT_SVH

// property that holds at every clock edge outside reset
`define URRSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must be followed by an outcome in the next cycle
`define URRSA_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

// File: design/urrsa_pkg.sv
// shared types and constants of the usage ranked slot assigner
// no dependencies
package urrsa_pkg;

	localparam int NUM_REGS = 64;
	localparam int NUM_PRIO = 6;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 16;
	localparam int SLOT_W   = 7;
	localparam int LOCAL_W  = 8;
	localparam int USED_W   = 7;
	localparam int PRIO_W   = $clog2(NUM_PRIO);
	localparam int PCNT_W   = $clog2(NUM_PRIO + 1);
	localparam int RANK_W   = $clog2(NUM_REGS);
	localparam int ECNT_W   = $clog2(NUM_REGS + 1);
	localparam int STEP_W   = IDX_W;

	// priority register indexes on the configuration port
	typedef enum logic [PRIO_W-1:0] {
		CFG_STACK     = 3'd0,
		CFG_FUNC_ADDR = 3'd1,
		CFG_ARG0      = 3'd2,
		CFG_ARG1      = 3'd3,
		CFG_ARG2      = 3'd4,
		CFG_ARG3      = 3'd5
	} cfg_idx_t;

	localparam logic [IDX_W-1:0] PRIO_RST [NUM_PRIO] = '{
		6'd29, 6'd32, 6'd4, 6'd5, 6'd6, 6'd7
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIO,
		ST_SETUP,
		ST_RANK,
		ST_FINAL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] reg_index;
		logic [CNT_W-1:0] usage_count;
		logic             is_last;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]          out_reg;
		logic signed [LOCAL_W-1:0] local_slot;
		logic [USED_W-1:0]         locals_used;
		logic                      run_last;
	} out_item_t;

	// count and index that circulate around the ring
	typedef struct packed {
		logic             elig;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] idx;
	} token_t;

	// final placement that shifts out toward cell zero
	typedef struct packed {
		logic              placed;
		logic [SLOT_W-1:0] slot;
	} res_t;

	typedef struct packed {
		logic load;
		logic prio;
		logic setup;
		logic rank;
		logic fin;
		logic emit;
	} phase_t;

	typedef struct packed {
		phase_t            ph;
		logic [IDX_W-1:0]  wr_idx;
		logic [CNT_W-1:0]  wr_count;
		logic [IDX_W-1:0]  prio_idx;
		logic [PCNT_W-1:0] prio_cnt;
	} cell_ctl_t;

endpackage

// File: design/urrsa_cell.sv
// one register cell: usage count, priority slot, rank counter, ring token
// depends on urrsa_pkg
module urrsa_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  urrsa_pkg::cell_ctl_t        ctl,
	input  logic [urrsa_pkg::IDX_W-1:0] my_idx,
	input  urrsa_pkg::token_t           tok_in,
	output urrsa_pkg::token_t           tok_out,
	input  urrsa_pkg::res_t             res_in,
	output urrsa_pkg::res_t             res_out,
	output logic                        prio_hit
);

	logic [urrsa_pkg::CNT_W-1:0]  count_q;
	logic                         taken_q;
	logic [urrsa_pkg::SLOT_W-1:0] pslot_q;
	logic [urrsa_pkg::RANK_W-1:0] rank_q;
	urrsa_pkg::token_t            tok_q;
	urrsa_pkg::res_t              res_q;

	logic nz;
	logic own_elig;
	logic beats;

	// eligibility for the ranked pass and the comparison against the token
	assign nz       = |count_q;
	assign own_elig = nz && !taken_q;
	assign beats    = tok_q.elig && own_elig &&
		((tok_q.count > count_q) || ((tok_q.count == count_q) && (tok_q.idx < my_idx)));
	assign prio_hit = ctl.ph.prio && (ctl.prio_idx == my_idx) && nz;

	assign tok_out = tok_q;
	assign res_out = res_q;

	// usage count and taken flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			taken_q <= 1'b0;
		end else if (ctl.ph.load && (ctl.wr_idx == my_idx)) begin
			count_q <= ctl.wr_count;
		end else if (prio_hit) begin
			taken_q <= 1'b1;
		end else if (ctl.ph.fin) begin
			count_q <= '0;
			taken_q <= 1'b0;
		end
	end

	// priority slot, rank and ring token
	always_ff @(posedge clk) begin
		if (prio_hit) begin
			pslot_q <= urrsa_pkg::SLOT_W'(ctl.prio_cnt);
		end
		if (ctl.ph.setup) begin
			tok_q  <= '{elig: own_elig, count: count_q, idx: my_idx};
			rank_q <= '0;
		end else if (ctl.ph.rank) begin
			tok_q <= tok_in;
			if (beats) begin
				rank_q <= rank_q + urrsa_pkg::RANK_W'(1);
			end
		end
	end

	// final placement, then shift toward cell zero
	always_ff @(posedge clk) begin
		if (ctl.ph.fin) begin
			res_q.placed <= own_elig || taken_q;
			res_q.slot   <= own_elig ?
				(urrsa_pkg::SLOT_W'(ctl.prio_cnt) + urrsa_pkg::SLOT_W'(rank_q)) : pslot_q;
		end else if (ctl.ph.emit) begin
			res_q <= res_in;
		end
	end

endmodule

// File: design/urrsa_ctrl.sv
// run sequencer: load, priority, setup, ranking ring, final latch, emission
// depends on urrsa_pkg and the assertion macro header
`include "usage_ranked_register_slot_assigner_core_assert.svh"

module urrsa_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         is_last,
	input  logic                         prio_hit,
	input  logic                         tok0_elig,
	output logic                         busy,
	output urrsa_pkg::phase_t            ph,
	output logic [urrsa_pkg::STEP_W-1:0] step,
	output logic [urrsa_pkg::PCNT_W-1:0] prio_cnt,
	output logic [urrsa_pkg::USED_W-1:0] locals_used
);

	urrsa_pkg::state_t            state_q;
	urrsa_pkg::state_t            state_d;
	logic [urrsa_pkg::STEP_W-1:0] step_q;
	logic [urrsa_pkg::PCNT_W-1:0] prio_cnt_q;
	logic [urrsa_pkg::ECNT_W-1:0] elig_cnt_q;
	logic                         prio_end;
	logic                         ring_end;

	assign prio_end = step_q == urrsa_pkg::STEP_W'(urrsa_pkg::NUM_PRIO - 1);
	assign ring_end = step_q == urrsa_pkg::STEP_W'(urrsa_pkg::NUM_REGS - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			urrsa_pkg::ST_IDLE: begin
				if (start && is_last) state_d = urrsa_pkg::ST_PRIO;
			end
			urrsa_pkg::ST_PRIO: begin
				if (prio_end) state_d = urrsa_pkg::ST_SETUP;
			end
			urrsa_pkg::ST_SETUP: begin
				state_d = urrsa_pkg::ST_RANK;
			end
			urrsa_pkg::ST_RANK: begin
				if (ring_end) state_d = urrsa_pkg::ST_FINAL;
			end
			urrsa_pkg::ST_FINAL: begin
				state_d = urrsa_pkg::ST_EMIT;
			end
			urrsa_pkg::ST_EMIT: begin
				if (ring_end) state_d = urrsa_pkg::ST_IDLE;
			end
			default: begin
				state_d = urrsa_pkg::ST_IDLE;
			end
		endcase
	end

	// phase strobes
	always_comb begin
		ph = '0;
		case (state_q)
			urrsa_pkg::ST_IDLE:  ph.load  = start;
			urrsa_pkg::ST_PRIO:  ph.prio  = 1'b1;
			urrsa_pkg::ST_SETUP: ph.setup = 1'b1;
			urrsa_pkg::ST_RANK:  ph.rank  = 1'b1;
			urrsa_pkg::ST_FINAL: ph.fin   = 1'b1;
			urrsa_pkg::ST_EMIT:  ph.emit  = 1'b1;
			default:             ph       = '0;
		endcase
	end

	assign busy        = state_q != urrsa_pkg::ST_IDLE;
	assign step        = step_q;
	assign prio_cnt    = prio_cnt_q;
	assign locals_used = urrsa_pkg::USED_W'(prio_cnt_q) + urrsa_pkg::USED_W'(elig_cnt_q);

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= urrsa_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if ((state_d != state_q) || (state_q == urrsa_pkg::ST_IDLE)) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + urrsa_pkg::STEP_W'(1);
			end
		end
	end

	// priority placements and eligible registers seen at cell zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_cnt_q <= '0;
			elig_cnt_q <= '0;
		end else begin
			if ((state_q == urrsa_pkg::ST_IDLE) && start && is_last) begin
				prio_cnt_q <= '0;
			end else if (prio_hit) begin
				prio_cnt_q <= prio_cnt_q + urrsa_pkg::PCNT_W'(1);
			end
			if (state_q == urrsa_pkg::ST_SETUP) begin
				elig_cnt_q <= '0;
			end else if ((state_q == urrsa_pkg::ST_RANK) && tok0_elig) begin
				elig_cnt_q <= elig_cnt_q + urrsa_pkg::ECNT_W'(1);
			end
		end
	end

	`URRSA_ASSERT(a_prio_bound, prio_cnt_q <= urrsa_pkg::PCNT_W'(urrsa_pkg::NUM_PRIO), "priority count overran")
	`URRSA_ASSERT(a_idle_step, (state_q == urrsa_pkg::ST_IDLE) |-> (step_q == '0), "step counter moved while idle")
	`URRSA_ASSERT_NEXT(a_final_emit, state_q == urrsa_pkg::ST_FINAL, (state_q == urrsa_pkg::ST_EMIT) && (step_q == '0), "emission did not follow final latch")
	`URRSA_ASSERT_NEXT(a_emit_end, (state_q == urrsa_pkg::ST_EMIT) && ring_end, state_q == urrsa_pkg::ST_IDLE, "emission ran past last register")

endmodule

// File: design/usage_ranked_register_slot_assigner_core.sv
// top level of the usage ranked slot assigner: ring of register cells and sequencer
// depends on urrsa_pkg, urrsa_cell and urrsa_ctrl
//
// Each start with busy low loads one usage count. An item marked last
// stores its count and then runs the assignment: priority placement, a
// setup step, a rotation of the counts once around the ring of cells so
// each cell ranks itself against all others, a step to latch the slots,
// and then NUM_REGS results on consecutive cycles in register order, one
// per cycle with result_valid high. Most of a run is spent in the ranking
// rotation and the emission shift. The receiver cannot stall: every result
// is shown for exactly one cycle. The usage counts are cleared by the run.
// The configuration port is always ready and must be written only while
// the block is idle.
module usage_ranked_register_slot_assigner_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  urrsa_pkg::in_item_t         item,
	output logic                        busy,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [urrsa_pkg::PRIO_W-1:0] cfg_index,
	input  logic [urrsa_pkg::IDX_W-1:0] cfg_data,
	output logic                        result_valid,
	output urrsa_pkg::out_item_t        result
);

	logic [urrsa_pkg::IDX_W-1:0]  prio_q [urrsa_pkg::NUM_PRIO];
	urrsa_pkg::phase_t            ph;
	logic [urrsa_pkg::STEP_W-1:0] step;
	logic [urrsa_pkg::PCNT_W-1:0] prio_cnt;
	logic [urrsa_pkg::USED_W-1:0] locals_used;
	urrsa_pkg::cell_ctl_t         ctl;
	urrsa_pkg::token_t            tok [urrsa_pkg::NUM_REGS];
	urrsa_pkg::res_t              res [urrsa_pkg::NUM_REGS];
	logic [urrsa_pkg::NUM_REGS-1:0] hit_vec;

	assign cfg_ready = 1'b1;

	// priority register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < urrsa_pkg::NUM_PRIO; i++) begin
				prio_q[i] <= urrsa_pkg::PRIO_RST[i];
			end
		end else if (cfg_valid && cfg_ready &&
				(cfg_index <= urrsa_pkg::PRIO_W'(urrsa_pkg::CFG_ARG3))) begin
			prio_q[cfg_index] <= cfg_data;
		end
	end

	urrsa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.is_last     (item.is_last),
		.prio_hit    (|hit_vec),
		.tok0_elig   (tok[0].elig),
		.busy        (busy),
		.ph          (ph),
		.step        (step),
		.prio_cnt    (prio_cnt),
		.locals_used (locals_used)
	);

	// broadcast control to the cells
	assign ctl.ph       = ph;
	assign ctl.wr_idx   = item.reg_index;
	assign ctl.wr_count = item.usage_count;
	assign ctl.prio_idx = prio_q[step[urrsa_pkg::PRIO_W-1:0]];
	assign ctl.prio_cnt = prio_cnt;

	// ring of cells: tokens move from cell i+1 to cell i, results shift toward cell zero
	for (genvar i = 0; i < urrsa_pkg::NUM_REGS; i++) begin : g_cell
		urrsa_pkg::res_t res_next;

		if (i == urrsa_pkg::NUM_REGS - 1) begin : g_tail
			assign res_next = '0;
		end else begin : g_body
			assign res_next = res[i+1];
		end

		urrsa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.my_idx   (urrsa_pkg::IDX_W'(i)),
			.tok_in   (tok[(i + 1) % urrsa_pkg::NUM_REGS]),
			.tok_out  (tok[i]),
			.res_in   (res_next),
			.res_out  (res[i]),
			.prio_hit (hit_vec[i])
		);
	end

	// result item from cell zero
	assign result_valid       = ph.emit;
	assign result.out_reg     = step[urrsa_pkg::IDX_W-1:0];
	assign result.local_slot  = res[0].placed ? $signed({1'b0, res[0].slot}) : '1;
	assign result.locals_used = locals_used;
	assign result.run_last    = step == urrsa_pkg::STEP_W'(urrsa_pkg::NUM_REGS - 1);

endmodule
